// ----- rtl/sedm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sedm_pkg;

  localparam int SAMPLE_BITS        = 16;
  localparam int DELAY_BITS         = 15;
  localparam int DEF_DEPTH_FRAMES   = 32768;
  localparam int DEF_CHANNELS       = 2;
  localparam logic [DELAY_BITS-1:0] SEEN_MAX = '1;
  localparam logic [1:0] MOD_STEP_QUO = 2'd2;
  localparam logic [1:0] MOD_STEP_SUB = 2'd1;
  localparam logic [1:0] MOD_STEP_FIX = 2'd0;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
  } out_word_t;

  typedef struct packed {
    logic accept;
    logic advance;
    logic bypass;
    logic warm;
  } lane_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/stereo_echo_delay_mixer_core.sv -----
// Stereo echo mixer: each output channel is floor((x[n] + x[n-D]) / 2).
// Input channel: in_valid / in_stall carrying in_word (left and right
// samples). Output channel: out_valid / out_stall carrying out_word.
// A word is taken at a clock edge with valid high and stall low.
// Config: cfg_valid / cfg_ready carrying the 15-bit delay D in frames.
// After a config write the read offset (D modulo the store depth) is
// reduced by a reciprocal multiply, a subtract and one correction;
// cfg_ready and the input are held off during that time.
// Path: a word is registered in the read stage and its result in the
// output register. Throughput: one word per cycle when not stalled or
// busy, set by one write and one read port per channel's delay memory.
// Outputs are zero until D frames have been received since reset.
// When the receiver stalls, one result waits in the output register, one
// in the read stage; in_stall rises when both are full, in reset or busy.
// Synchronous reset clears pointers, frame count and delay to zero; the
// delay memory is not cleared; warm-up zeroes outputs of unwritten reads.
`timescale 1ns / 1ps
`default_nettype none

module stereo_echo_delay_mixer_core
  import sedm_pkg::*;
#(
  parameter int DEPTH_FRAMES = DEF_DEPTH_FRAMES,
  parameter int CHANNELS     = DEF_CHANNELS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_word_t              in_word,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_word_t                  out_word,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [DELAY_BITS-1:0] cfg_data
);

  localparam int AW    = $clog2(DEPTH_FRAMES);
  localparam int DW    = $clog2(DEPTH_FRAMES + 1);
  localparam int SW    = DW + DELAY_BITS;
  localparam int PW    = ((AW > DELAY_BITS) ? AW : DELAY_BITS) + 1;
  localparam int RSH   = 2 * DELAY_BITS;
  localparam int RECIP = (1 << RSH) / DEPTH_FRAMES;
  localparam int PRW   = DELAY_BITS + RSH;

  logic [DELAY_BITS-1:0] delay_r;
  logic [DELAY_BITS-1:0] back_r, back_nxt;
  logic [DELAY_BITS-1:0] quo_r;
  logic [1:0]            step_r;
  logic                  busy_r;
  logic [AW-1:0]         wp_r;
  logic [DELAY_BITS-1:0] frames_seen_r;
  logic                  s1_valid_r;
  logic                  s1_warm_r;
  logic                  out_valid_r;

  logic           accept;
  logic           advance;
  logic           cfg_we;
  logic           warm;
  logic [PRW-1:0] prod;
  logic [SW-1:0]  qd;
  logic [PW-1:0]  diff;
  logic [PW-1:0]  rp_wide;
  logic [AW-1:0]  rp;
  lane_ctl_t      ctl;
  logic signed [SAMPLE_BITS-1:0] mix [CHANNELS];

  assign cfg_we    = cfg_valid && cfg_ready;
  assign cfg_ready = rst_n && !busy_r;
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = !rst_n || busy_r || (s1_valid_r && !advance);
  assign accept    = in_valid && !in_stall;
  assign warm      = frames_seen_r < delay_r;
  assign out_valid = out_valid_r;

  // offset reduction: quotient estimate low by at most one, fixed last step
  assign prod = PRW'(back_r) * PRW'(RECIP);
  assign qd   = SW'(quo_r) * SW'(DEPTH_FRAMES);
  always_comb begin
    back_nxt = back_r;
    case (step_r)
      MOD_STEP_SUB: begin
        back_nxt = back_r - qd[DELAY_BITS-1:0];
      end
      MOD_STEP_FIX: begin
        if (SW'(back_r) >= SW'(DEPTH_FRAMES)) begin
          back_nxt = back_r - DELAY_BITS'(DEPTH_FRAMES);
        end
      end
      default: begin
        back_nxt = back_r;
      end
    endcase
  end

  assign diff    = PW'(wp_r) - PW'(back_r);
  assign rp_wide = diff[PW-1] ? (diff + PW'(DEPTH_FRAMES)) : diff;
  assign rp      = rp_wide[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r       <= '0;
      back_r        <= '0;
      quo_r         <= '0;
      step_r        <= '0;
      busy_r        <= 1'b0;
      wp_r          <= '0;
      frames_seen_r <= '0;
      s1_valid_r    <= 1'b0;
      s1_warm_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        delay_r <= cfg_data;
        back_r  <= cfg_data;
        step_r  <= MOD_STEP_QUO;
        busy_r  <= 1'b1;
      end else if (busy_r) begin
        back_r <= back_nxt;
        if (step_r == MOD_STEP_QUO) begin
          quo_r <= prod[RSH +: DELAY_BITS];
        end
        if (step_r == MOD_STEP_FIX) begin
          busy_r <= 1'b0;
        end else begin
          step_r <= step_r - 2'd1;
        end
      end
      if (accept) begin
        wp_r <= (wp_r == AW'(DEPTH_FRAMES - 1)) ? '0 : wp_r + AW'(1);
        if (frames_seen_r != SEEN_MAX) begin
          frames_seen_r <= frames_seen_r + DELAY_BITS'(1);
        end
        s1_warm_r  <= warm;
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    ctl.accept  = accept;
    ctl.advance = advance;
    ctl.bypass  = (back_r == '0);
    ctl.warm    = s1_warm_r;
  end

  genvar c;
  generate
    for (c = 0; c < CHANNELS; c++) begin : g_lane
      sedm_lane #(
        .DEPTH_FRAMES (DEPTH_FRAMES)
      ) u_lane (
        .clk    (clk),
        .ctl    (ctl),
        .waddr  (wp_r),
        .raddr  (rp),
        .sample ((c == 0) ? in_word.sample_left : in_word.sample_right),
        .mix_r  (mix[c])
      );
    end
  endgenerate

  assign out_word.out_left = mix[0];
  generate
    if (CHANNELS > 1) begin : g_stereo
      assign out_word.out_right = mix[CHANNELS-1];
    end else begin : g_mono
      assign out_word.out_right = '0;
    end
  endgenerate

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> in_stall) else $error("input open during offset reduction");

  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |-> in_stall)
    else $error("input open with both stages full");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r) else $error("accepted word lost");

  a_seen_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && frames_seen_r == SEEN_MAX) |=> (frames_seen_r == SEEN_MAX))
    else $error("frame count wrapped");

endmodule

`default_nettype wire

// ----- rtl/sedm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sedm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sedm_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sedm_lane
  import sedm_pkg::*;
#(
  parameter int DEPTH_FRAMES = DEF_DEPTH_FRAMES
) (
  input  wire logic                              clk,
  input  wire lane_ctl_t                         ctl,
  input  wire logic [$clog2(DEPTH_FRAMES)-1:0]   waddr,
  input  wire logic [$clog2(DEPTH_FRAMES)-1:0]   raddr,
  input  wire logic signed [SAMPLE_BITS-1:0]     sample,
  output logic signed [SAMPLE_BITS-1:0]          mix_r
);

  logic signed [SAMPLE_BITS-1:0] cur_r;
  logic                          byp_r;
  logic        [SAMPLE_BITS-1:0] rdata;
  logic signed [SAMPLE_BITS-1:0] dly;
  logic signed [SAMPLE_BITS:0]   sum;
  logic signed [SAMPLE_BITS-1:0] mix_nxt;

  sedm_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH_FRAMES)
  ) u_store (
    .clk   (clk),
    .we    (ctl.accept),
    .waddr (waddr),
    .wdata (sample),
    .re    (ctl.accept),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cur_r <= sample;
      byp_r <= ctl.bypass;
    end
    if (ctl.advance) begin
      mix_r <= mix_nxt;
    end
  end

  // read slot equal to write slot: delayed sample is the current one
  assign dly = byp_r ? cur_r : $signed(rdata);
  assign sum = {cur_r[SAMPLE_BITS-1], cur_r} + {dly[SAMPLE_BITS-1], dly};

  always_comb begin
    if (ctl.warm) begin
      mix_nxt = '0;
    end else begin
      mix_nxt = sum[SAMPLE_BITS:1];
    end
  end

endmodule

`default_nettype wire
